[sv/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg
// Shared widths, register indexes, control types and saturation for the
// stereo ping-pong delay.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int SW         = 24;
	localparam int AW         = 17;
	localparam int LINE_DEPTH = 1 << AW;
	localparam int FRAC_W     = 8;
	localparam int DLY_W      = 25;
	localparam int FB_W       = 17;
	localparam int G_W        = 18;
	localparam int GAIN_FRAC  = 16;
	localparam int CFG_W      = 25;
	localparam int IDX_W      = 3;

	localparam logic signed [31:0] SAT_HI = (32'sd1 <<< (SW - 1)) - 32'sd1;
	localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

	typedef enum logic [IDX_W-1:0] {
		REG_LEFT_DELAY  = 3'd0,
		REG_RIGHT_DELAY = 3'd1,
		REG_FEEDBACK    = 3'd2,
		REG_DRY         = 3'd3,
		REG_WET         = 3'd4
	} spd_reg_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic intp;
		logic mul;
		logic wr;
	} spd_ctl_t;

	typedef struct packed {
		logic [FB_W-1:0] fb;
		logic [G_W-1:0]  dry;
		logic [G_W-1:0]  wet;
	} spd_gain_t;

	function automatic logic signed [SW-1:0] sat(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = v;
		end
		return r[SW-1:0];
	endfunction

endpackage

[sv/spd_lane.sv]
// ----------------------------------------------------------------------------
// spd_lane
// One channel: delay line memory, interpolated read, feedback sum and mix.
// ----------------------------------------------------------------------------
module spd_lane import spd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spd_ctl_t              ctl,
	input  logic [AW-1:0]         wp,
	input  logic [AW:0]           fill,
	input  logic [DLY_W-1:0]      delay,
	input  spd_gain_t             gain,
	input  logic signed [SW-1:0]  x,
	input  logic signed [SW-1:0]  wdata,
	output logic signed [SW-1:0]  fb_sum,
	output logic signed [SW-1:0]  mix
);

	logic signed [SW-1:0] mem [LINE_DEPTH];

	logic [AW-1:0]        back1, back2, addr1, addr2;
	logic [AW:0]          need1, need2;
	logic [AW-1:0]        addr1_q, addr2_q;
	logic                 v1_q, v2_q;
	logic [FRAC_W-1:0]    frac_q;
	logic signed [SW-1:0] x_q;

	logic signed [SW-1:0] rd1_s1, rd2_s1;
	logic signed [SW-1:0] y1, y2;
	logic signed [SW:0]   diff;
	logic signed [SW+FRAC_W+1:0] prod;
	logic signed [SW-1:0] y_s2;

	logic signed [SW+FB_W:0]  fbp_s3;
	logic signed [SW+G_W:0]   dryp_s3, wetp_s3;
	logic signed [SW+G_W+1:0] mix_sum;

	assign back1 = delay[FRAC_W +: AW];
	assign back2 = back1 + 1'b1;
	// slot zero frames back is the oldest one, written only once the line is full
	assign need1 = {back1 == '0, back1};
	assign need2 = {back2 == '0, back2};
	assign addr1 = wp - back1;
	assign addr2 = wp - back2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else if (ctl.load) begin
			v1_q <= fill >= need1;
			v2_q <= fill >= need2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			addr1_q <= addr1;
			addr2_q <= addr2;
			frac_q  <= delay[FRAC_W-1:0];
			x_q     <= x;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wp] <= wdata;
		end
		if (ctl.rd) begin
			rd1_s1 <= mem[addr1_q];
			rd2_s1 <= mem[addr2_q];
		end
	end

	assign y1   = v1_q ? rd1_s1 : '0;
	assign y2   = v2_q ? rd2_s1 : '0;
	assign diff = {y2[SW-1], y2} - {y1[SW-1], y1};
	assign prod = diff * $signed({1'b0, frac_q});

	always_ff @(posedge clk) begin
		if (ctl.intp) begin
			y_s2 <= y1 + SW'(prod >>> FRAC_W);
		end
		if (ctl.mul) begin
			fbp_s3  <= y_s2 * $signed({1'b0, gain.fb});
			dryp_s3 <= x_q * $signed({1'b0, gain.dry});
			wetp_s3 <= y_s2 * $signed({1'b0, gain.wet});
		end
	end

	assign mix_sum = dryp_s3 + wetp_s3;
	assign fb_sum  = sat(32'(x_q) + 32'(fbp_s3 >>> GAIN_FRAC));
	assign mix     = sat(32'(mix_sum >>> GAIN_FRAC));

endmodule

[sv/stereo_ping_pong_delay.sv]
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay
// Stereo ping-pong delay with feedback: two delay lanes, cross-coupled writes.
// ----------------------------------------------------------------------------
// Each frame runs the sequencer steps in order: accept, a two-port line read
// per channel, interpolation, the gain multiplies, then line write-back and
// output load; that sequencer sets the rate, and a new frame is accepted
// while a finished word waits on the master side. The lines read as zero
// until written, by way of a fill count, so no clearing pass follows reset.
module stereo_ping_pong_delay import spd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [47:0]      s_tdata,   // right_in [47:24], left_in [23:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata    // right_out [47:24], left_out [23:0]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_INT,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [DLY_W-1:0] left_delay_q, right_delay_q;
	spd_gain_t        gain_q;
	logic [AW-1:0]    wp_q;
	logic [AW:0]      fill_q;

	spd_ctl_t             ctl;
	logic                 fin_go;
	logic signed [SW-1:0] l_fb, r_fb, l_mix, r_mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_delay_q  <= DLY_W'(6144000);
			right_delay_q <= DLY_W'(6144000);
			gain_q.fb     <= FB_W'(32768);
			gain_q.dry    <= G_W'(65536);
			gain_q.wet    <= G_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_DELAY:  left_delay_q  <= cfg_data[DLY_W-1:0];
				REG_RIGHT_DELAY: right_delay_q <= cfg_data[DLY_W-1:0];
				REG_FEEDBACK:    gain_q.fb     <= cfg_data[FB_W-1:0];
				REG_DRY:         gain_q.dry    <= cfg_data[G_W-1:0];
				REG_WET:         gain_q.wet    <= cfg_data[G_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign fin_go   = (state_q == ST_FIN) && (!m_tvalid || m_tready);

	assign ctl.load = s_tvalid && s_tready;
	assign ctl.rd   = (state_q == ST_RD);
	assign ctl.intp = (state_q == ST_INT);
	assign ctl.mul  = (state_q == ST_MUL);
	assign ctl.wr   = fin_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			fill_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			if (fin_go) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {r_mix, l_mix};
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_INT;
				ST_INT: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						wp_q <= wp_q + 1'b1;
						if (fill_q != (AW+1)'(LINE_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// crossed writes: left feedback sum lands in the right line and vice versa
	spd_lane u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wp     (wp_q),
		.fill   (fill_q),
		.delay  (left_delay_q),
		.gain   (gain_q),
		.x      (s_tdata[SW-1:0]),
		.wdata  (r_fb),
		.fb_sum (l_fb),
		.mix    (l_mix)
	);

	spd_lane u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wp     (wp_q),
		.fill   (fill_q),
		.delay  (right_delay_q),
		.gain   (gain_q),
		.x      (s_tdata[2*SW-1:SW]),
		.wdata  (l_fb),
		.fb_sum (r_fb),
		.mix    (r_mix)
	);

endmodule
